>>> rtl/core/cms_pkg.sv
// Shared constants, types and codes for the common l-mer motif search block.
// No dependencies; cms_search and the top level use this package by scoped names.
package cms_pkg;

	localparam int MAX_SEQS = 16;
	localparam int MAX_LEN  = 64;
	localparam int SEQ_W    = $clog2(MAX_SEQS);
	localparam int POS_W    = $clog2(MAX_LEN);
	localparam int ADDR_W   = SEQ_W + POS_W;
	localparam int DEPTH    = MAX_SEQS * MAX_LEN;
	localparam int BASE_W   = 2;
	localparam int CNT_W    = 10;
	localparam int NSEQ_W   = 5;
	localparam int LEN_W    = 7;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Input operation codes.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Configuration register indexes (byte address = 4 * index).
	localparam logic [1:0] REG_NUM_SEQS = 2'd0;
	localparam logic [1:0] REG_SEQ_LEN  = 2'd1;
	localparam logic [1:0] REG_LMER_LEN = 2'd2;

	typedef struct packed {
		logic [NSEQ_W-1:0] num_seqs;
		logic [LEN_W-1:0]  seq_len;
		logic [LEN_W-1:0]  lmer_len;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              found;
		logic [POS_W-1:0]  start_position;
		logic [CNT_W-1:0]  occurrence_count;
	} rsp_t;

endpackage

>>> rtl/core/cms_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module cms_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/cms_search.sv
// Search sequencer: walks windows of sequence 0 against all windows of the other
// sequences, one base compare per read of the two store copies. Uses cms_pkg.
module cms_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  cms_pkg::cfg_t               cfg,
	input  logic [cms_pkg::BASE_W-1:0]  rdata0,
	input  logic [cms_pkg::BASE_W-1:0]  rdatak,
	output logic [cms_pkg::ADDR_W-1:0]  raddr0,
	output logic [cms_pkg::ADDR_W-1:0]  raddrk,
	output logic                        busy,
	output cms_pkg::rsp_t               rsp,
	input  logic                        rsp_take
);

	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_CHECK, S_FIN} state_t;

	state_t                          state_q;
	logic [cms_pkg::POS_W-1:0]       i_q, l_q, t_q;
	logic [cms_pkg::SEQ_W-1:0]       k_q;
	logic [cms_pkg::POS_W-1:0]       last_q, ll_last_q;
	logic [cms_pkg::SEQ_W-1:0]       ns_last_q;
	logic [cms_pkg::MAX_SEQS-1:0]    flags_q;
	logic [cms_pkg::CNT_W-1:0]       count_q;
	logic                            found_q;
	logic [cms_pkg::POS_W-1:0]       start_q;
	logic [cms_pkg::CNT_W-1:0]       total_q;

	// Effective configuration at search start.
	logic [cms_pkg::LEN_W-1:0]       sl_eff;
	logic [cms_pkg::LEN_W-1:0]       last_full;
	logic [cms_pkg::LEN_W-1:0]       ll_m1;
	logic [cms_pkg::SEQ_W-1:0]       ns_last;
	logic                            cfg_ok;

	// Compare step.
	logic                            eq, win_end, hit, all_ok, in_use;
	logic [cms_pkg::MAX_SEQS-1:0]    flags_nx;
	logic [cms_pkg::CNT_W-1:0]       count_nx;

	always_comb begin
		sl_eff = (cfg.seq_len > cms_pkg::LEN_W'(cms_pkg::MAX_LEN)) ?
			cms_pkg::LEN_W'(cms_pkg::MAX_LEN) : cfg.seq_len;
		cfg_ok = (cfg.lmer_len != '0) && (sl_eff != '0) && (cfg.lmer_len <= sl_eff);
		last_full = sl_eff - cfg.lmer_len;
		ll_m1 = cfg.lmer_len - cms_pkg::LEN_W'(1);
		if (cfg.num_seqs > cms_pkg::NSEQ_W'(cms_pkg::MAX_SEQS)) begin
			ns_last = cms_pkg::SEQ_W'(cms_pkg::MAX_SEQS - 1);
		end else if (cfg.num_seqs < cms_pkg::NSEQ_W'(2)) begin
			ns_last = cms_pkg::SEQ_W'(1);
		end else begin
			ns_last = cms_pkg::SEQ_W'(cfg.num_seqs - cms_pkg::NSEQ_W'(1));
		end
	end

	always_comb begin
		eq = (rdata0 == rdatak);
		win_end = !eq || (t_q == ll_last_q);
		hit = eq && (t_q == ll_last_q);
		flags_nx = flags_q;
		if (hit) begin
			flags_nx[k_q] = 1'b1;
		end
		count_nx = (hit && (count_q != cms_pkg::COUNT_MAX)) ? count_q + cms_pkg::CNT_W'(1) :
			count_q;
		// Every sequence in use past sequence 0 must hold the window at least once.
		all_ok = 1'b1;
		for (int j = 0; j < cms_pkg::MAX_SEQS; j++) begin
			in_use = (j != 0) && (cms_pkg::SEQ_W'(j) <= ns_last_q);
			all_ok = all_ok && (flags_nx[j] || !in_use);
		end
	end

	assign raddr0 = {cms_pkg::SEQ_W'(0), i_q + t_q};
	assign raddrk = {k_q, l_q + t_q};
	assign busy = (state_q != S_IDLE);

	always_comb begin
		rsp.valid = (state_q == S_FIN);
		rsp.found = found_q;
		rsp.start_position = start_q;
		rsp.occurrence_count = total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			i_q       <= '0;
			k_q       <= '0;
			l_q       <= '0;
			t_q       <= '0;
			last_q    <= '0;
			ll_last_q <= '0;
			ns_last_q <= '0;
			flags_q   <= '0;
			count_q   <= '0;
			found_q   <= 1'b0;
			start_q   <= '0;
			total_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						i_q       <= '0;
						k_q       <= cms_pkg::SEQ_W'(1);
						l_q       <= '0;
						t_q       <= '0;
						flags_q   <= '0;
						count_q   <= '0;
						last_q    <= last_full[cms_pkg::POS_W-1:0];
						ll_last_q <= ll_m1[cms_pkg::POS_W-1:0];
						ns_last_q <= ns_last;
						found_q   <= 1'b0;
						start_q   <= '0;
						total_q   <= '0;
						state_q   <= cfg_ok ? S_ISSUE : S_FIN;
					end
				end
				S_ISSUE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!win_end) begin
						t_q     <= t_q + cms_pkg::POS_W'(1);
						state_q <= S_ISSUE;
					end else begin
						t_q <= '0;
						if (l_q != last_q) begin
							flags_q <= flags_nx;
							count_q <= count_nx;
							l_q     <= l_q + cms_pkg::POS_W'(1);
							state_q <= S_ISSUE;
						end else if (k_q != ns_last_q) begin
							flags_q <= flags_nx;
							count_q <= count_nx;
							l_q     <= '0;
							k_q     <= k_q + cms_pkg::SEQ_W'(1);
							state_q <= S_ISSUE;
						end else if (all_ok) begin
							flags_q <= flags_nx;
							count_q <= count_nx;
							found_q <= 1'b1;
							start_q <= i_q;
							total_q <= count_nx;
							state_q <= S_FIN;
						end else if (i_q != last_q) begin
							// Next start position in sequence 0; the marks start over.
							i_q     <= i_q + cms_pkg::POS_W'(1);
							k_q     <= cms_pkg::SEQ_W'(1);
							l_q     <= '0;
							flags_q <= '0;
							count_q <= '0;
							state_q <= S_ISSUE;
						end else begin
							flags_q <= flags_nx;
							count_q <= count_nx;
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (rsp_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/common_lmer_motif_search.sv
// Top level of the common l-mer motif search: APB registers, two copies of the
// base store (cms_ram), the search sequencer (cms_search) and the output register.
//
// Channel   Direction  Handshake             Payload
// in        to block   in_valid / in_stall   func, seq_index, position, base
// out       from block out_valid / out_stall found, start_position, occurrence_count
// apb       to block   psel/penable/pready   paddr, pwdata, pwrite, prdata
//
// A load beat is written to the store at its accept edge.
// A search beat keeps in_stall high from its accept edge until the result is handed on.
// Each base compare issues a store read in S_ISSUE and checks the registered read data
// in S_CHECK, a window compare ends at its first mismatch, and a last state, S_FIN,
// hands the result to the output register. The store is undefined after reset; no
// clearing pass is run. A stalled output register holds the search in S_FIN; a result
// in the output register does not block loads.
module common_lmer_motif_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [cms_pkg::SEQ_W-1:0]     seq_index,
	input  logic [cms_pkg::POS_W-1:0]     position,
	input  logic [cms_pkg::BASE_W-1:0]    base,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          found,
	output logic [cms_pkg::POS_W-1:0]     start_position,
	output logic [cms_pkg::CNT_W-1:0]     occurrence_count,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cms_pkg::PADDR_W-1:0]   paddr,
	input  logic [cms_pkg::PDATA_W-1:0]   pwdata,
	output logic [cms_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	cms_pkg::cfg_t                  cfg_q;
	cms_pkg::rsp_t                  rsp;
	logic                           busy, in_acc, ram_we, start, rsp_take, reg_wr;
	logic [1:0]                     reg_idx;
	logic [cms_pkg::ADDR_W-1:0]     waddr, raddr0, raddrk;
	logic [cms_pkg::BASE_W-1:0]     rdata0, rdatak;
	logic                           out_valid_q, found_q;
	logic [cms_pkg::POS_W-1:0]      start_q;
	logic [cms_pkg::CNT_W-1:0]      count_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_seqs <= cms_pkg::NSEQ_W'(2);
			cfg_q.seq_len  <= cms_pkg::LEN_W'(64);
			cfg_q.lmer_len <= cms_pkg::LEN_W'(8);
		end else if (reg_wr) begin
			unique case (reg_idx)
				cms_pkg::REG_NUM_SEQS: cfg_q.num_seqs <= pwdata[cms_pkg::NSEQ_W-1:0];
				cms_pkg::REG_SEQ_LEN:  cfg_q.seq_len  <= pwdata[cms_pkg::LEN_W-1:0];
				cms_pkg::REG_LMER_LEN: cfg_q.lmer_len <= pwdata[cms_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			cms_pkg::REG_NUM_SEQS: prdata = cms_pkg::PDATA_W'(cfg_q.num_seqs);
			cms_pkg::REG_SEQ_LEN:  prdata = cms_pkg::PDATA_W'(cfg_q.seq_len);
			cms_pkg::REG_LMER_LEN: prdata = cms_pkg::PDATA_W'(cfg_q.lmer_len);
			default:               prdata = '0;
		endcase
	end

	assign in_stall = busy;
	assign in_acc   = in_valid && !in_stall;
	assign ram_we   = in_acc && (func == cms_pkg::FUNC_LOAD);
	assign start    = in_acc && (func == cms_pkg::FUNC_SEARCH);
	assign waddr    = {seq_index, position};

	// Two identical copies give one read port for sequence 0 and one for sequence k.
	cms_ram #(.WIDTH(cms_pkg::BASE_W), .DEPTH(cms_pkg::DEPTH)) u_ram0 (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (base),
		.raddr (raddr0),
		.rdata (rdata0)
	);

	cms_ram #(.WIDTH(cms_pkg::BASE_W), .DEPTH(cms_pkg::DEPTH)) u_ramk (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (base),
		.raddr (raddrk),
		.rdata (rdatak)
	);

	cms_search u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cfg      (cfg_q),
		.rdata0   (rdata0),
		.rdatak   (rdatak),
		.raddr0   (raddr0),
		.raddrk   (raddrk),
		.busy     (busy),
		.rsp      (rsp),
		.rsp_take (rsp_take)
	);

	assign rsp_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			start_q     <= '0;
			count_q     <= '0;
		end else if (rsp_take) begin
			out_valid_q <= rsp.valid;
			if (rsp.valid) begin
				found_q <= rsp.found;
				start_q <= rsp.start_position;
				count_q <= rsp.occurrence_count;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign found            = found_q;
	assign start_position   = start_q;
	assign occurrence_count = count_q;

	a_search_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == cms_pkg::FUNC_SEARCH) |=> in_stall)
		else $error("search beat accepted but input not stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (start_position == '0) && (occurrence_count == '0))
		else $error("result without a motif carries nonzero fields");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> (occurrence_count != '0))
		else $error("found motif with zero occurrences");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !ram_we)
		else $error("store written during a search");

endmodule

>>> sim/common_lmer_motif_search_tb.sv
// Self-checking testbench for the common l-mer motif search block: loads bases, runs
// searches under random idling and stalls, and compares each result with a built-in predictor.
// Depends on cms_pkg and common_lmer_motif_search from rtl/core.
module common_lmer_motif_search_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SEQS = cms_pkg::MAX_SEQS;
	localparam int MAX_LEN  = cms_pkg::MAX_LEN;
	localparam int SEQ_W    = cms_pkg::SEQ_W;
	localparam int POS_W    = cms_pkg::POS_W;
	localparam int BASE_W   = cms_pkg::BASE_W;
	localparam int CNT_W    = cms_pkg::CNT_W;
	localparam int NSEQ_W   = cms_pkg::NSEQ_W;
	localparam int LEN_W    = cms_pkg::LEN_W;
	localparam int PADDR_W  = cms_pkg::PADDR_W;
	localparam int PDATA_W  = cms_pkg::PDATA_W;
	localparam int DEPTH    = cms_pkg::DEPTH;
	localparam logic [CNT_W-1:0] COUNT_MAX = cms_pkg::COUNT_MAX;
	localparam logic FUNC_LOAD   = cms_pkg::FUNC_LOAD;
	localparam logic FUNC_SEARCH = cms_pkg::FUNC_SEARCH;
	localparam logic [1:0] REG_NUM_SEQS = cms_pkg::REG_NUM_SEQS;
	localparam logic [1:0] REG_SEQ_LEN  = cms_pkg::REG_SEQ_LEN;
	localparam logic [1:0] REG_LMER_LEN = cms_pkg::REG_LMER_LEN;

	localparam int HALF_PERIOD = 2;
	localparam int TARGET_BEATS = 1600;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic              func;
		logic [SEQ_W-1:0]  seq_index;
		logic [POS_W-1:0]  position;
		logic [BASE_W-1:0] base;
	} motif_beat_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] start_position;
		logic [CNT_W-1:0] occurrence_count;
	} motif_hit_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                func = FUNC_LOAD;
	logic [SEQ_W-1:0]    seq_index = '0;
	logic [POS_W-1:0]    position = '0;
	logic [BASE_W-1:0]   base = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                found;
	logic [POS_W-1:0]    start_position;
	logic [CNT_W-1:0]    occurrence_count;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Register copies as the block sees them, reset values included.
	logic [NSEQ_W-1:0]   cfg_num_seqs = 5'd2;
	logic [LEN_W-1:0]    cfg_seq_len = 7'd64;
	logic [LEN_W-1:0]    cfg_lmer_len = 7'd8;

	// Store contents as seen by accepted beats, and as planned by the stimulus.
	logic [BASE_W-1:0]   base_mem [DEPTH];
	logic [BASE_W-1:0]   plan_mem [DEPTH];
	bit                  plan_written [DEPTH];

	motif_beat_t         beat_queue [$];
	motif_hit_t          expected_hits [$];
	motif_beat_t         cur_beat;
	motif_hit_t          want_hit;
	int                  beats_queued = 0;
	int                  mismatches = 0;
	int                  gap_left = 0;
	int                  burst_left = 1;
	int                  stall_mode = 0;
	int                  mode_left = 0;
	longint              cycle_count = 0;
	longint              cycle_limit = 100000;

	common_lmer_motif_search u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.seq_index        (seq_index),
		.position         (position),
		.base             (base),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.found            (found),
		.start_position   (start_position),
		.occurrence_count (occurrence_count),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > cycle_limit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void append_beat(input motif_beat_t b);
		beat_queue.insert(beat_queue.size(), b);
	endfunction

	function automatic void append_hit(input motif_hit_t h);
		expected_hits.insert(expected_hits.size(), h);
	endfunction

	function automatic int eff_num_seqs();
		int ns;
		ns = cfg_num_seqs;
		if (ns > MAX_SEQS)
			ns = MAX_SEQS;
		if (ns < 2)
			ns = 2;
		return ns;
	endfunction

	function automatic int eff_seq_len();
		return (cfg_seq_len > MAX_LEN) ? MAX_LEN : int'(cfg_seq_len);
	endfunction

	// Tries each window of sequence 0 in order; the first one present in every other
	// sequence in use wins, with the number of matching windows seen for it.
	function automatic motif_hit_t search_motif();
		motif_hit_t hit;
		int ns, sl, ll, cnt;
		bit seen [MAX_SEQS];
		bit all_seen, same;
		hit = '0;
		ns = eff_num_seqs();
		sl = eff_seq_len();
		ll = cfg_lmer_len;
		if (ll == 0 || sl == 0 || ll > sl)
			return hit;
		for (int i = 0; i + ll <= sl && !hit.found; i++) begin
			cnt = 0;
			for (int k = 0; k < MAX_SEQS; k++)
				seen[k] = 1'b0;
			for (int k = 1; k < ns; k++) begin
				for (int l = 0; l + ll <= sl; l++) begin
					same = 1'b1;
					for (int t = 0; t < ll && same; t++)
						same = (base_mem[i + t] == base_mem[k * MAX_LEN + l + t]);
					if (same) begin
						seen[k] = 1'b1;
						if (cnt < COUNT_MAX)
							cnt++;
					end
				end
			end
			all_seen = 1'b1;
			for (int k = 1; k < ns; k++)
				if (!seen[k])
					all_seen = 1'b0;
			if (all_seen) begin
				hit.found = 1'b1;
				hit.start_position = POS_W'(i);
				hit.occurrence_count = CNT_W'(cnt);
			end
		end
		return hit;
	endfunction

	task automatic apply_beat(input motif_beat_t b);
		if (b.func == FUNC_LOAD)
			base_mem[b.seq_index * MAX_LEN + b.position] = b.base;
		else
			append_hit(search_motif());
	endtask

	// Sender: bursts of beats separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_LOAD;
			seq_index <= '0;
			position <= '0;
			base <= '0;
			cur_beat = '0;
			gap_left = 0;
			burst_left = 1;
		end else begin
			if (in_valid && !in_stall)
				apply_beat(cur_beat);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (beat_queue.size() > 0) begin
					cur_beat = beat_queue.pop_front();
					in_valid <= 1'b1;
					func <= cur_beat.func;
					seq_index <= cur_beat.seq_index;
					position <= cur_beat.position;
					base <= cur_beat.base;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern switches between free-running, random and mostly stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode = 0;
			mode_left = 50;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 1);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("result beat with no search pending");
			end else begin
				want_hit = expected_hits.pop_front();
				if (found !== want_hit.found)
					report_mismatch($sformatf("found %b, expected %b", found, want_hit.found));
				if (start_position !== want_hit.start_position)
					report_mismatch($sformatf("start_position %0d, expected %0d",
						start_position, want_hit.start_position));
				if (occurrence_count !== want_hit.occurrence_count)
					report_mismatch($sformatf("occurrence_count %0d, expected %0d",
						occurrence_count, want_hit.occurrence_count));
			end
		end
	end

	task automatic wait_idle();
		@(posedge clk);
		while (beat_queue.size() != 0 || in_valid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Unused upper data bits carry random values; the register keeps only its own width.
	task automatic apb_write(input logic [1:0] idx, input int value);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		case (idx)
			REG_NUM_SEQS: word[NSEQ_W-1:0] = NSEQ_W'(value);
			REG_SEQ_LEN:  word[LEN_W-1:0] = LEN_W'(value);
			REG_LMER_LEN: word[LEN_W-1:0] = LEN_W'(value);
			default: word = PDATA_W'(value);
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_NUM_SEQS: cfg_num_seqs = word[NSEQ_W-1:0];
			REG_SEQ_LEN:  cfg_seq_len = word[LEN_W-1:0];
			REG_LMER_LEN: cfg_lmer_len = word[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(input int ns, input int sl, input int ll);
		wait_idle();
		apb_write(REG_NUM_SEQS, ns);
		apb_write(REG_SEQ_LEN, sl);
		apb_write(REG_LMER_LEN, ll);
	endtask

	task automatic queue_load(input int seq, input int pos, input int b);
		motif_beat_t beat;
		beat.func = FUNC_LOAD;
		beat.seq_index = SEQ_W'(seq);
		beat.position = POS_W'(pos);
		beat.base = BASE_W'(b);
		append_beat(beat);
		plan_mem[seq * MAX_LEN + pos] = BASE_W'(b);
		plan_written[seq * MAX_LEN + pos] = 1'b1;
		beats_queued++;
		cycle_limit += 60;
	endtask

	// Any base of the active region that was never loaded gets one first, so the
	// search never reads an unwritten entry.
	task automatic queue_search();
		motif_beat_t beat;
		int ns, sl, ll, w;
		longint cost;
		ns = eff_num_seqs();
		sl = eff_seq_len();
		ll = cfg_lmer_len;
		for (int k = 0; k < ns; k++)
			for (int p = 0; p < sl; p++)
				if (!plan_written[k * MAX_LEN + p])
					queue_load(k, p, $urandom_range(0, 3));
		beat.func = FUNC_SEARCH;
		beat.seq_index = SEQ_W'($urandom());
		beat.position = POS_W'($urandom());
		beat.base = BASE_W'($urandom());
		append_beat(beat);
		beats_queued++;
		cost = 2200;
		if (ll >= 1 && ll <= sl) begin
			w = sl - ll + 1;
			cost += longint'(w) * w * (ns - 1) * (2 * ll + 4);
		end
		cycle_limit += 4 * cost;
	endtask

	// One search with fresh content: a fill from a random alphabet, usually a motif
	// copied from sequence 0 into the others (sometimes one left out), then a few
	// stray loads that may break it.
	task automatic random_round();
		int ns, sl, ll, alpha, sym0, at, skip, p;
		bit full;
		ns = eff_num_seqs();
		sl = eff_seq_len();
		ll = cfg_lmer_len;
		alpha = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(1, 3);
		sym0 = $urandom_range(0, 3);
		full = (ns * sl <= 64) || ($urandom_range(0, 3) == 0);
		for (int k = 0; k < ns; k++)
			for (int q = 0; q < sl; q++)
				if (full || !plan_written[k * MAX_LEN + q] || $urandom_range(0, 3) == 0)
					queue_load(k, q, (sym0 + $urandom_range(0, alpha - 1)) % 4);
		if (ll >= 1 && ll <= sl && $urandom_range(0, 9) < 6) begin
			at = $urandom_range(0, (sl > 16 && sl - ll > 2) ? 2 : sl - ll);
			skip = ($urandom_range(0, 3) == 0) ? $urandom_range(1, ns - 1) : 0;
			for (int k = 1; k < ns; k++) begin
				if (k != skip) begin
					p = $urandom_range(0, sl - ll);
					for (int t = 0; t < ll; t++)
						queue_load(k, p + t, int'(plan_mem[at + t]));
				end
			end
		end
		repeat ($urandom_range(0, 6))
			queue_load($urandom_range(0, MAX_SEQS - 1), $urandom_range(0, MAX_LEN - 1),
				$urandom_range(0, 3));
		queue_search();
	endtask

	initial begin
		int ext_ns [7] = '{31, 16, 2, 3, 16, 0, 1};
		int ext_sl [7] = '{16, 8, 127, 64, 16, 1, 64};
		int ext_ll [7] = '{3, 8, 6, 64, 127, 1, 1};
		int ns, sl, ll, s, r;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: all four bases in both sequences, extreme indexes, then the
		// configurations that must report nothing found.
		configure(2, 4, 2);
		for (int p = 0; p < 4; p++)
			queue_load(0, p, p);
		queue_load(1, 0, 3);
		queue_load(1, 1, 2);
		queue_load(1, 2, 0);
		queue_load(1, 3, 1);
		queue_search();
		queue_load(15, 63, 3);
		queue_load(8, 32, 2);
		queue_search();
		wait_idle();
		apb_write(REG_UNUSED, 1);
		queue_search();
		configure(2, 4, 5);
		queue_search();
		configure(2, 4, 0);
		queue_search();
		configure(2, 0, 2);
		queue_search();
		configure(1, 4, 4);
		queue_search();

		for (int e = 0; e < 7; e++) begin
			configure(ext_ns[e], ext_sl[e], ext_ll[e]);
			repeat ($urandom_range(1, 2))
				random_round();
		end

		// Large sequence counts go with short sequences and the other way round.
		while (beats_queued < TARGET_BEATS) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				ns = $urandom_range(2, 6);
				sl = $urandom_range(1, 16);
			end else if (r < 8) begin
				ns = $urandom_range(0, 31);
				sl = $urandom_range(1, 16);
			end else begin
				ns = $urandom_range(0, 3);
				sl = $urandom_range(17, 127);
			end
			s = (sl > MAX_LEN) ? MAX_LEN : sl;
			r = $urandom_range(0, 9);
			if (r < 7)
				ll = $urandom_range(1, (s < 8) ? s : 8);
			else if (r < 9)
				ll = $urandom_range(0, s + 2);
			else
				ll = $urandom_range(0, 127);
			configure(ns, sl, ll);
			repeat ($urandom_range(1, 4))
				random_round();
		end

		wait_idle();
		if (expected_hits.size() != 0)
			report_mismatch($sformatf("%0d searches never returned a result",
				expected_hits.size()));
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/cms_pkg.sv
rtl/core/cms_ram.sv
rtl/core/cms_search.sv
rtl/core/common_lmer_motif_search.sv
sim/common_lmer_motif_search_tb.sv
